FILE: design/tlbpt_pkg.sv
`default_nettype none
package tlbpt_pkg;

   localparam int PAGE_W      = 8;
   localparam int FRAME_W     = 3;
   localparam int CORE_FRAMES = 8;
   localparam int PAGE_BYTES  = 256;
   localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
   localparam int ADDR_W      = 11;
   localparam int COUNT_W     = 32;

   typedef logic [PAGE_W-1:0]  page_type;
   typedef logic [FRAME_W-1:0] frame_type;
   typedef logic [COUNT_W-1:0] count_type;

endpackage
`default_nettype wire

FILE: design/tlb_and_core_page_translation_unit.sv
// Page translation unit: a small fully associative TLB in front of an
// 8-frame core page table.
// req_ channel: one virtual page per item. rsp_ channel: one result per item
// with tlb_hit, page_fault, frame, real_address (frame times page size) and
// the running fault total. Both channels use valid/stall; an item moves on a
// clock edge with valid high and stall low.
// csr_ channel: writes victim_page, the page evicted first on a page fault.
// From acceptance, an item passes one input register, then the TLB probe,
// core search, refill choice and all state updates happen in one pass into
// the result register. One item per cycle is sustained while rsp_stall is low,
// since each item leaves its state updated before the next one is processed.
// When rsp_stall is held, the result register holds its item, the item in
// the input register waits, and req_stall rises once the input register is
// full. Synchronous reset empties both registers, invalidates all TLB
// entries and core frames, and clears the LRU clock, the fault counter and
// victim_page. There is no clearing pass; the unit takes items right after
// reset.
`default_nettype none
module tlb_and_core_page_translation_unit
   import tlbpt_pkg::*;
#(
   parameter int TLB_ENTRIES = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [PAGE_W-1:0]   req_virtual_page,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_tlb_hit,
   output logic                     rsp_page_fault,
   output logic [FRAME_W-1:0]       rsp_frame,
   output logic [ADDR_W-1:0]        rsp_real_address,
   output logic [COUNT_W-1:0]       rsp_fault_total,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [PAGE_W-1:0]   csr_victim_page
);

   localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);

   // input register
   logic      req_valid_ff;
   page_type  req_page_ff;

   // result register
   logic      rsp_valid_ff;
   logic      rsp_hit_ff;
   logic      rsp_fault_ff;
   frame_type rsp_frame_ff;
   count_type rsp_total_ff;

   // state
   page_type  victim_page_ff;
   page_type  tlb_page_ff    [TLB_ENTRIES];
   frame_type tlb_frame_ff   [TLB_ENTRIES];
   logic      tlb_valid_ff   [TLB_ENTRIES];
   count_type tlb_stamp_ff   [TLB_ENTRIES];
   count_type tlb_clock_ff;
   page_type  core_page_ff   [CORE_FRAMES];
   logic      core_present_ff[CORE_FRAMES];
   count_type fault_count_ff;

   page_type  tlb_page_in    [TLB_ENTRIES];
   frame_type tlb_frame_in   [TLB_ENTRIES];
   logic      tlb_valid_in   [TLB_ENTRIES];
   count_type tlb_stamp_in   [TLB_ENTRIES];
   count_type tlb_clock_in;
   page_type  core_page_in   [CORE_FRAMES];
   logic      core_present_in[CORE_FRAMES];
   count_type fault_count_in;

   logic                 fire;
   count_type            clk_probe;
   count_type            clk_fill;
   logic                 hit;
   logic [TLB_IDX_W-1:0] hit_idx;
   logic                 core_found;
   frame_type            core_idx;
   logic                 vict_found;
   frame_type            vict_idx;
   logic                 empty_found;
   frame_type            empty_idx;
   frame_type            fault_frame;
   frame_type            frame_sel;
   logic                 fault;
   logic                 inv_found;
   logic [TLB_IDX_W-1:0] inv_idx;
   logic [TLB_IDX_W-1:0] lru_idx;
   count_type            lru_best;
   logic [TLB_IDX_W-1:0] fill_idx;

   assign fire      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !fire;
   assign csr_ready = 1'b1;

   assign clk_probe = tlb_clock_ff + 1'b1;
   assign clk_fill  = tlb_clock_ff + 2'd2;

   // tlb probe, lowest matching entry wins
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (tlb_valid_ff[i] && tlb_page_ff[i] == req_page_ff) begin
            hit     = 1'b1;
            hit_idx = TLB_IDX_W'(i);
         end
      end
   end

   // core table searches
   always_comb begin
      core_found  = 1'b0;
      core_idx    = '0;
      vict_found  = 1'b0;
      vict_idx    = '0;
      empty_found = 1'b0;
      empty_idx   = '0;
      for (int i = CORE_FRAMES - 1; i >= 0; i--) begin
         if (core_present_ff[i] && core_page_ff[i] == req_page_ff) begin
            core_found = 1'b1;
            core_idx   = FRAME_W'(i);
         end
         if (core_present_ff[i] && core_page_ff[i] == victim_page_ff) begin
            vict_found = 1'b1;
            vict_idx   = FRAME_W'(i);
         end
         if (!core_present_ff[i]) begin
            empty_found = 1'b1;
            empty_idx   = FRAME_W'(i);
         end
      end
   end

   assign fault_frame = vict_found ? vict_idx : (empty_found ? empty_idx : '0);
   assign fault       = !hit && !core_found;
   assign frame_sel   = hit ? tlb_frame_ff[hit_idx]
                            : (core_found ? core_idx : fault_frame);

   // refill slot: first invalid entry, else oldest stamp, lowest index on ties
   always_comb begin
      inv_found = 1'b0;
      inv_idx   = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (!tlb_valid_ff[i]) begin
            inv_found = 1'b1;
            inv_idx   = TLB_IDX_W'(i);
         end
      end
      lru_idx  = '0;
      lru_best = tlb_stamp_ff[0];
      for (int i = 1; i < TLB_ENTRIES; i++) begin
         if (tlb_stamp_ff[i] < lru_best) begin
            lru_best = tlb_stamp_ff[i];
            lru_idx  = TLB_IDX_W'(i);
         end
      end
   end

   assign fill_idx = inv_found ? inv_idx : lru_idx;

   always_comb begin
      tlb_page_in     = tlb_page_ff;
      tlb_frame_in    = tlb_frame_ff;
      tlb_valid_in    = tlb_valid_ff;
      tlb_stamp_in    = tlb_stamp_ff;
      tlb_clock_in    = tlb_clock_ff;
      core_page_in    = core_page_ff;
      core_present_in = core_present_ff;
      fault_count_in  = fault_count_ff;
      if (fire) begin
         if (hit) begin
            tlb_clock_in          = clk_probe;
            tlb_stamp_in[hit_idx] = clk_probe;
         end else begin
            tlb_clock_in           = clk_fill;
            tlb_page_in[fill_idx]  = req_page_ff;
            tlb_frame_in[fill_idx] = frame_sel;
            tlb_valid_in[fill_idx] = 1'b1;
            tlb_stamp_in[fill_idx] = clk_fill;
            if (fault) begin
               fault_count_in               = fault_count_ff + 1'b1;
               core_page_in[fault_frame]    = req_page_ff;
               core_present_in[fault_frame] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         victim_page_ff <= '0;
         tlb_clock_ff   <= '0;
         fault_count_ff <= '0;
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            tlb_valid_ff[i] <= 1'b0;
         end
         for (int i = 0; i < CORE_FRAMES; i++) begin
            core_present_ff[i] <= 1'b0;
         end
      end else begin
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            victim_page_ff <= csr_victim_page;
         end
         tlb_clock_ff    <= tlb_clock_in;
         fault_count_ff  <= fault_count_in;
         tlb_valid_ff    <= tlb_valid_in;
         core_present_ff <= core_present_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_page_ff <= req_virtual_page;
      end
      if (fire) begin
         rsp_hit_ff   <= hit;
         rsp_fault_ff <= fault;
         rsp_frame_ff <= frame_sel;
         rsp_total_ff <= fault_count_in;
      end
      tlb_page_ff  <= tlb_page_in;
      tlb_frame_ff <= tlb_frame_in;
      tlb_stamp_ff <= tlb_stamp_in;
      core_page_ff <= core_page_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tlb_hit      = rsp_hit_ff;
   assign rsp_page_fault   = rsp_fault_ff;
   assign rsp_frame        = rsp_frame_ff;
   assign rsp_real_address = ADDR_W'(rsp_frame_ff) << PAGE_SHIFT;
   assign rsp_fault_total  = rsp_total_ff;

   // a fault only happens on a tlb miss
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_fault_ff))
      else $error("tlb hit and page fault reported together");

   // the fault counter moves only when an item is processed
   assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(fault_count_ff))
      else $error("fault counter changed without an item");

   // a faulting item reports the updated counter
   assert property (@(posedge clock) disable iff (reset)
      fire && fault |=> rsp_valid_ff && rsp_total_ff == fault_count_ff)
      else $error("fault total does not match fault counter");

endmodule
`default_nettype wire
